// File: src/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants for the deadline timer table: item layouts,
// operation and result codes, register indexes and the control interface
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package dtt_pkg;

  // field widths
  localparam int FUNC_W  = 2;
  localparam int SESS_W  = 5;
  localparam int IVL_W   = 32;
  localparam int NOW_W   = 48;
  localparam int KIND_W  = 2;
  localparam int WAIT_W  = 32;

  // configuration port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WAIT  = 2'd2;

  // register reset values in ms
  localparam logic [WAIT_W-1:0] IDLE_WAIT_RST = 32'd1000;
  localparam logic [WAIT_W-1:0] MAX_WAIT_RST  = 32'd60000;
  localparam logic [WAIT_W-1:0] MIN_WAIT_RST  = 32'd10;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_WATCH   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UNWATCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

  // result codes
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WAIT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SESS_W-1:0] session;
    logic [IVL_W-1:0]  interval_ms;
    logic [NOW_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SESS_W-1:0] expired_session;
    logic [WAIT_W-1:0] wait_ms;
    logic              wake;
    logic              last;
  } out_item_t;

  // sequencer to datapath commands
  typedef struct packed {
    logic load;       // capture the accepted item
    logic exec;       // carry out watch or unwatch
    logic scan_clr;   // restart the minimum search
    logic scan_rd;    // read the next slot of the table
    logic calc_left;  // time left to the earliest deadline
    logic calc_wait;  // cap or idle wait
    logic calc_floor; // next wakeup and floored wait
    logic post_ack;
    logic post_exp;   // also disarms the expired slot
    logic post_rep;
  } dtt_cmd_t;

  // datapath to sequencer status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              scan_last;
    logic              due;
    logic              out_free;
  } dtt_stat_t;

endpackage

// File: src/dtt_ctrl.sv
// ----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer of the deadline timer table: decodes each item, runs the slot
// scans of a tick and posts results into the output register.
// ----------------------------------------------------------------------------
module dtt_ctrl
  import dtt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dtt_stat_t stat_i,
  output dtt_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_ACK    = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_DRAIN  = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_EXPIRE = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;
  localparam logic [3:0] S_FLOOR  = 4'd8;
  localparam logic [3:0] S_REPORT = 4'd9;

  logic [3:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.func == FUNC_TICK) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = S_SCAN;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_ACK;
        end
      end
      S_ACK: begin
        if (stat_i.out_free) begin
          cmd_o.post_ack = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      // last slot is compared here
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.calc_left = 1'b1;
        state_d = stat_i.due ? S_EXPIRE : S_WAIT;
      end
      S_EXPIRE: begin
        if (stat_i.out_free) begin
          cmd_o.post_exp = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_WAIT: begin
        cmd_o.calc_wait = 1'b1;
        state_d         = S_FLOOR;
      end
      S_FLOOR: begin
        cmd_o.calc_floor = 1'b1;
        state_d          = S_REPORT;
      end
      S_REPORT: begin
        if (stat_i.out_free) begin
          cmd_o.post_rep = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/dtt_datapath.sv
// ----------------------------------------------------------------------------
// dtt_datapath
// Deadline memory, armed bits, minimum search over the slots, wait
// arithmetic and the output register of the deadline timer table.
// ----------------------------------------------------------------------------
module dtt_datapath
  import dtt_pkg::*;
#(
  parameter int SLOTS     = 32,
  parameter int TIME_BITS = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_item_t          in_item_i,
  input  logic [WAIT_W-1:0] idle_wait_i,
  input  logic [WAIT_W-1:0] max_wait_i,
  input  logic [WAIT_W-1:0] min_wait_i,
  input  dtt_cmd_t          cmd_i,
  output dtt_stat_t         stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output out_item_t         out_item_o
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int TW1    = TIME_BITS + 1;

  // captured item
  logic [FUNC_W-1:0]    func_q;
  logic [SESS_W-1:0]    sess_q;
  logic [IVL_W-1:0]     ivl_q;
  logic [TIME_BITS-1:0] now_q;
  logic [63:0]          now_ext;

  // table
  logic [TIME_BITS-1:0] mem_q [SLOTS];
  logic [TIME_BITS-1:0] rdata_q;
  logic [SLOTS-1:0]     armed_q;

  // scan
  logic [SLOT_W-1:0]    idx_q;
  logic [SLOT_W-1:0]    rd_idx_q;
  logic                 cmp_en_q;
  logic                 found_q;
  logic [TIME_BITS-1:0] best_q;
  logic [SLOT_W-1:0]    best_idx_q;
  logic                 hit;

  // arithmetic
  logic                 in_range;
  logic [SLOT_W-1:0]    sess_addr;
  logic                 mem_we;
  logic [TW1-1:0]       dl_sum;
  logic [TIME_BITS-1:0] dl_sat;
  logic [TW1-1:0]       nw_sum;
  logic [TIME_BITS-1:0] nw_sat;
  logic [TIME_BITS-1:0] left_q;
  logic [WAIT_W-1:0]    wait_q;
  logic [WAIT_W-1:0]    rep_q;
  logic [TIME_BITS-1:0] next_wakeup_q;
  logic                 wake_q;

  // output register
  logic                 out_valid_q;
  out_item_t            out_q;

  assign now_ext   = 64'(in_item_i.now_ms);
  assign in_range  = 32'(sess_q) < 32'(SLOTS);
  assign sess_addr = SLOT_W'(sess_q);
  assign mem_we    = cmd_i.exec && (func_q == FUNC_WATCH) && in_range;

  // saturating deadline and next wakeup
  assign dl_sum = {1'b0, now_q} + TW1'(ivl_q);
  assign dl_sat = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
  assign nw_sum = {1'b0, now_q} + TW1'(wait_q);
  assign nw_sat = nw_sum[TIME_BITS] ? '1 : nw_sum[TIME_BITS-1:0];

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_item_i.func;
      sess_q <= in_item_i.session;
      ivl_q  <= in_item_i.interval_ms;
      now_q  <= now_ext[TIME_BITS-1:0];
    end
  end

  // deadline memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[sess_addr] <= dl_sat;
    end
    rdata_q <= mem_q[idx_q];
  end

  // armed bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else if (cmd_i.exec && in_range) begin
      if (func_q == FUNC_WATCH) begin
        armed_q[sess_addr] <= 1'b1;
      end else if (func_q == FUNC_UNWATCH) begin
        armed_q[sess_addr] <= 1'b0;
      end
    end else if (cmd_i.post_exp) begin
      armed_q[best_idx_q] <= 1'b0;
    end
  end

  // wake flag for the watch acknowledgement
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      wake_q <= mem_we && (dl_sat < next_wakeup_q);
    end
  end

  // scan address and read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      cmp_en_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.scan_rd;
      if (cmd_i.scan_clr) begin
        idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
  end

  // running minimum, strict compare keeps the lower slot on a tie
  assign hit = cmp_en_q && armed_q[rd_idx_q] && (!found_q || (rdata_q < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      found_q <= 1'b0;
    end else if (hit) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      best_q     <= rdata_q;
      best_idx_q <= rd_idx_q;
    end
  end

  // wait arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_left) begin
      left_q <= best_q - now_q;
    end
    if (cmd_i.calc_wait) begin
      if (!found_q) begin
        wait_q <= idle_wait_i;
      end else if (left_q > TIME_BITS'(max_wait_i)) begin
        wait_q <= max_wait_i;
      end else begin
        wait_q <= left_q[WAIT_W-1:0];
      end
    end
    if (cmd_i.calc_floor) begin
      rep_q <= (wait_q <= min_wait_i) ? min_wait_i : wait_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_wakeup_q <= '0;
    end else if (cmd_i.calc_floor) begin
      next_wakeup_q <= nw_sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.post_ack || cmd_i.post_exp || cmd_i.post_rep) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post_ack) begin
      out_q.kind            <= KIND_ACK;
      out_q.expired_session <= '0;
      out_q.wait_ms         <= '0;
      out_q.wake            <= wake_q;
      out_q.last            <= 1'b1;
    end else if (cmd_i.post_exp) begin
      out_q.kind            <= KIND_EXPIRED;
      out_q.expired_session <= SESS_W'(best_idx_q);
      out_q.wait_ms         <= '0;
      out_q.wake            <= 1'b0;
      out_q.last            <= 1'b0;
    end else if (cmd_i.post_rep) begin
      out_q.kind            <= KIND_WAIT;
      out_q.expired_session <= '0;
      out_q.wait_ms         <= rep_q;
      out_q.wake            <= 1'b0;
      out_q.last            <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // status
  assign stat_o.func      = func_q;
  assign stat_o.scan_last = idx_q == SLOT_W'(SLOTS - 1);
  assign stat_o.due       = found_q && (best_q <= now_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  // a result is only posted into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.post_ack || cmd_i.post_exp || cmd_i.post_rep) |-> (!out_valid_q || out_ready_i))
    else $error("result posted over an untaken result");

  // an expiry always names an armed slot found by the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.post_exp |-> (found_q && armed_q[best_idx_q]))
    else $error("expiry of a slot that is not armed");

  // table writes never overlap a scan compare
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && cmp_en_q))
    else $error("deadline write during scan");
`endif

endmodule

// File: src/deadline_timer_table_unit.sv
// ----------------------------------------------------------------------------
// deadline_timer_table_unit
// Top level of the deadline timer table: configuration registers, sequencer
// and datapath.
// ----------------------------------------------------------------------------
// One item is handled at a time. A watch, unwatch or unknown operation is
// executed and then acknowledged in the output register. A tick scans the
// deadline memory through its single read port and makes one pass per
// expired slot plus a final one; each result it posts waits while the
// output side stalls. The deadline memory needs no clearing after reset;
// the block is ready at once.
module deadline_timer_table_unit
  import dtt_pkg::*;
#(
  parameter int SLOTS     = 32,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [WAIT_W-1:0] idle_wait_q;
  logic [WAIT_W-1:0] max_wait_q;
  logic [WAIT_W-1:0] min_wait_q;
  dtt_cmd_t          cmd;
  dtt_stat_t         stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_wait_q <= IDLE_WAIT_RST;
      max_wait_q  <= MAX_WAIT_RST;
      min_wait_q  <= MIN_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDLE_WAIT: idle_wait_q <= cfg_data_i;
        CFG_MAX_WAIT:  max_wait_q  <= cfg_data_i;
        CFG_MIN_WAIT:  min_wait_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  dtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  dtt_datapath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .idle_wait_i (idle_wait_q),
    .max_wait_i  (max_wait_q),
    .min_wait_i  (min_wait_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
